@@ src/limit_order_book_matcher_top_defines.svh @@
// assertion macros shared by the checker
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH

// checked property, quiet while reset is held
`define LOBM_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lobm check failed");

// checked property, also sampled during reset
`define LOBM_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("lobm check failed");

`endif

@@ src/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types for the order book matcher: cell commands and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lobm_pkg;

    // command applied to every cell of one book in a cycle
    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_DEC = 2'd1,
        OP_POP = 2'd2,
        OP_INS = 2'd3
    } t_op;

    typedef struct packed {
        t_op  op;
        logic buy;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_REST = 5'b00100,
        S_FORM = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

@@ src/lobm_cell.sv @@
// ----------------------------------------------------------------------------
// lobm_cell
// One resting order slot: price, quantity and the total of its price level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_cell
    import lobm_pkg::*;
#(
    parameter int PB = 32,
    parameter int QB = 32,
    parameter int LW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [PB-1:0] i_key,
    input  logic [QB-1:0] i_amt,
    input  logic          i_first,
    input  logic          i_l_valid,
    input  logic [PB-1:0] i_l_price,
    input  logic [QB-1:0] i_l_qty,
    input  logic [LW-1:0] i_l_level,
    input  logic          i_l_flag,
    input  logic          i_r_valid,
    input  logic [PB-1:0] i_r_price,
    input  logic [QB-1:0] i_r_qty,
    input  logic [LW-1:0] i_r_adj_level,
    output logic          o_valid,
    output logic [PB-1:0] o_price,
    output logic [QB-1:0] o_qty,
    output logic [LW-1:0] o_level,
    output logic [LW-1:0] o_adj_level,
    output logic          o_flag
);

    logic          r_valid, n_valid;
    logic [PB-1:0] r_price, n_price;
    logic [QB-1:0] r_qty, n_qty;
    logic [LW-1:0] r_level, n_level;
    logic          eq;
    logic [LW-1:0] amt_w;
    logic [LW-1:0] adj;

    assign amt_w = LW'(i_amt);
    assign eq    = r_valid && (r_price == i_key);

    // level total after a trade at this price
    assign adj = (eq && (i_ctl.op == OP_DEC || i_ctl.op == OP_POP)) ?
                 (r_level - amt_w) : r_level;

    // slot lies at or after the insert point
    assign o_flag = !r_valid || (i_ctl.buy ? (r_price < i_key) : (r_price > i_key));

    // next slot contents
    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_qty   = r_qty;
        n_level = r_level;
        case (i_ctl.op)
            OP_DEC: begin
                n_level = adj;
                if (i_first) begin
                    n_qty = r_qty - i_amt;
                end
            end
            OP_POP: begin
                n_valid = i_r_valid;
                n_price = i_r_price;
                n_qty   = i_r_qty;
                n_level = i_r_adj_level;
            end
            OP_INS: begin
                if (o_flag && i_l_flag) begin
                    n_valid = i_l_valid;
                    n_price = i_l_price;
                    n_qty   = i_l_qty;
                    n_level = i_l_level;
                end else if (o_flag) begin
                    n_valid = 1'b1;
                    n_price = i_key;
                    n_qty   = i_amt;
                    n_level = (i_l_valid && i_l_price == i_key) ?
                              (i_l_level + amt_w) : amt_w;
                end else if (eq) begin
                    n_level = r_level + amt_w;
                end
            end
            default: begin
            end
        endcase
    end

    // slot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price <= n_price;
        r_qty   <= n_qty;
        r_level <= n_level;
    end

    assign o_valid     = r_valid;
    assign o_price     = r_price;
    assign o_qty       = r_qty;
    assign o_level     = r_level;
    assign o_adj_level = adj;

endmodule

@@ src/lobm_book.sv @@
// ----------------------------------------------------------------------------
// lobm_book
// One side of the book as a sorted row of cells, best price at the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_book
    import lobm_pkg::*;
#(
    parameter int N  = 32,
    parameter int PB = 32,
    parameter int QB = 32,
    parameter int LW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [PB-1:0] i_key,
    input  logic [QB-1:0] i_amt,
    output logic          o_head_valid,
    output logic [PB-1:0] o_head_price,
    output logic [QB-1:0] o_head_qty,
    output logic [LW-1:0] o_head_level,
    output logic          o_next_valid,
    output logic [PB-1:0] o_next_price,
    output logic          o_full
);

    logic          c_valid [N];
    logic [PB-1:0] c_price [N];
    logic [QB-1:0] c_qty   [N];
    logic [LW-1:0] c_level [N];
    logic [LW-1:0] c_adj   [N];
    logic          c_flag  [N];

    // row of cells, each linked to both neighbours
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic          l_valid, l_flag, r_valid;
        logic [PB-1:0] l_price, r_price;
        logic [QB-1:0] l_qty, r_qty;
        logic [LW-1:0] l_level, r_adj;

        if (i == 0) begin : g_head
            assign l_valid = 1'b0;
            assign l_price = '0;
            assign l_qty   = '0;
            assign l_level = '0;
            assign l_flag  = 1'b0;
        end else begin : g_mid
            assign l_valid = c_valid[i-1];
            assign l_price = c_price[i-1];
            assign l_qty   = c_qty[i-1];
            assign l_level = c_level[i-1];
            assign l_flag  = c_flag[i-1];
        end

        if (i == N-1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_price = '0;
            assign r_qty   = '0;
            assign r_adj   = '0;
        end else begin : g_body
            assign r_valid = c_valid[i+1];
            assign r_price = c_price[i+1];
            assign r_qty   = c_qty[i+1];
            assign r_adj   = c_adj[i+1];
        end

        lobm_cell #(.PB(PB), .QB(QB), .LW(LW)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_key         (i_key),
            .i_amt         (i_amt),
            .i_first       (i == 0),
            .i_l_valid     (l_valid),
            .i_l_price     (l_price),
            .i_l_qty       (l_qty),
            .i_l_level     (l_level),
            .i_l_flag      (l_flag),
            .i_r_valid     (r_valid),
            .i_r_price     (r_price),
            .i_r_qty       (r_qty),
            .i_r_adj_level (r_adj),
            .o_valid       (c_valid[i]),
            .o_price       (c_price[i]),
            .o_qty         (c_qty[i]),
            .o_level       (c_level[i]),
            .o_adj_level   (c_adj[i]),
            .o_flag        (c_flag[i])
        );
    end

    assign o_head_valid = c_valid[0];
    assign o_head_price = c_price[0];
    assign o_head_qty   = c_qty[0];
    assign o_head_level = c_level[0];
    assign o_next_valid = c_valid[1];
    assign o_next_price = c_price[1];
    assign o_full       = c_valid[N-1];

endmodule

@@ src/limit_order_book_matcher_top.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority matcher with a buy book and a sell book of cells.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one order word: action, side,
// price and quantity. Output channel o_out_valid / i_out_ready carries result
// words; o_last marks the final word of an order. A zero quantity order gives
// no word. Every word carries both tops of book as they stand at that point.
// An order is accepted in S_IDLE; S_STEP then trades the resting orders one at
// a time and closes the sweep, after a result word for a level that is still
// open; S_REST inserts a remainder, S_FORM forms each result word and S_FIN
// closes the order. The sweep walks the head cell of the opposite book, one
// order per cycle, except while it pauses to form a result word.
// o_in_ready is high only while the sequencer is idle.
// Results pass through a one-word holding stage and an output register; a
// stalled receiver holds the sequencer at its next result word.
// Reset empties both books and clears the holding and output valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module limit_order_book_matcher_top
    import lobm_pkg::*;
#(
    parameter int ORDERS_PER_SIDE = 32,
    parameter int PRICE_BITS      = 32,
    parameter int QUANTITY_BITS   = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic                     i_side,
    input  logic [PRICE_BITS-1:0]    i_price,
    input  logic [QUANTITY_BITS-1:0] i_quantity,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PRICE_BITS-1:0]    o_best_ask,
    output logic [QUANTITY_BITS+$clog2(ORDERS_PER_SIDE)-1:0] o_ask_depth,
    output logic                     o_ask_present,
    output logic [PRICE_BITS-1:0]    o_best_bid,
    output logic [QUANTITY_BITS+$clog2(ORDERS_PER_SIDE)-1:0] o_bid_depth,
    output logic                     o_bid_present,
    output logic                     o_has_fill,
    output logic [PRICE_BITS-1:0]    o_trade_price,
    output logic [QUANTITY_BITS-1:0] o_trade_qty,
    output logic                     o_clipped,
    output logic                     o_rejected,
    output logic                     o_last
);

    localparam int PB = PRICE_BITS;
    localparam int QB = QUANTITY_BITS;
    localparam int LW = QUANTITY_BITS + $clog2(ORDERS_PER_SIDE);

    // sequencer and order registers
    t_state        r_state, n_state, r_ret, n_ret;
    logic          r_market, r_buy, r_clipped, r_any;
    logic [PB-1:0] r_price, r_lvl_price, n_lvl_price;
    logic [QB-1:0] r_rem, n_rem, r_acc, n_acc;
    logic [LW-1:0] r_tot_bid, n_tot_bid, r_tot_ask, n_tot_ask;

    // pending result event
    logic          r_ev_fill, n_ev_fill, r_ev_rej, n_ev_rej;
    logic [PB-1:0] r_ev_price, n_ev_price;
    logic [QB-1:0] r_ev_qty, n_ev_qty;

    // holding stage
    logic          r_pv;
    logic [PB-1:0] r_p_ap, r_p_bp, r_p_fp;
    logic [LW-1:0] r_p_aq, r_p_bq;
    logic [QB-1:0] r_p_fq;
    logic          r_p_apr, r_p_bpr, r_p_fill, r_p_clip, r_p_rej;

    // output register
    logic          r_ov;
    logic [PB-1:0] r_o_ap, r_o_bp, r_o_fp;
    logic [LW-1:0] r_o_aq, r_o_bq;
    logic [QB-1:0] r_o_fq;
    logic          r_o_apr, r_o_bpr, r_o_fill, r_o_clip, r_o_rej, r_o_last;

    // book ports
    t_op           cmd_op;
    logic          cmd_to_buy;
    logic [PB-1:0] cmd_key;
    logic [QB-1:0] cmd_amt;
    t_cell_ctl     ctl_buy, ctl_sell;
    logic          b_hv, b_nv, b_full, s_hv, s_nv, s_full;
    logic [PB-1:0] b_hp, b_np, s_hp, s_np;
    logic [QB-1:0] b_hq, s_hq;
    logic [LW-1:0] b_hl, s_hl;

    // opposite and own side views
    logic          o_hv, o_nv, own_hv, own_full;
    logic [PB-1:0] o_hp, o_np, own_hp;
    logic [QB-1:0] o_hq, take, acc_sum;
    logic [LW-1:0] o_tot;
    logic          cont, pop, show, out_free, accept, clip;

    assign o_hv     = r_buy ? s_hv : b_hv;
    assign o_nv     = r_buy ? s_nv : b_nv;
    assign o_hp     = r_buy ? s_hp : b_hp;
    assign o_np     = r_buy ? s_np : b_np;
    assign o_hq     = r_buy ? s_hq : b_hq;
    assign own_hv   = r_buy ? b_hv : s_hv;
    assign own_hp   = r_buy ? b_hp : s_hp;
    assign own_full = r_buy ? b_full : s_full;
    assign o_tot    = i_side ? r_tot_ask : r_tot_bid;

    assign out_free = !r_ov || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign clip     = i_action && (LW'(i_quantity) > o_tot);

    // sweep step terms
    assign cont    = o_hv && (r_rem != '0) &&
                     (r_market || (r_buy ? !(o_hp > r_price) : !(o_hp < r_price)));
    assign take    = (o_hq < r_rem) ? o_hq : r_rem;
    assign pop     = (o_hq == take);
    assign acc_sum = r_acc + take;
    assign show    = !own_hv || (r_buy ? (r_price >= own_hp) : (r_price <= own_hp));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_lvl_price = r_lvl_price;
        n_tot_bid   = r_tot_bid;
        n_tot_ask   = r_tot_ask;
        n_ev_fill   = r_ev_fill;
        n_ev_rej    = r_ev_rej;
        n_ev_price  = r_ev_price;
        n_ev_qty    = r_ev_qty;
        cmd_op      = OP_NOP;
        cmd_to_buy  = !r_buy;
        cmd_key     = o_hp;
        cmd_amt     = take;
        case (r_state)
            S_IDLE: begin
                if (accept && i_quantity != '0) begin
                    n_rem   = clip ? QB'(o_tot) : i_quantity;
                    n_acc   = '0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (cont) begin
                    cmd_op      = pop ? OP_POP : OP_DEC;
                    n_rem       = r_rem - take;
                    n_lvl_price = o_hp;
                    if (r_buy) begin
                        n_tot_ask = r_tot_ask - LW'(take);
                    end else begin
                        n_tot_bid = r_tot_bid - LW'(take);
                    end
                    if (pop && (!o_nv || o_np != o_hp)) begin
                        n_ev_fill  = 1'b1;
                        n_ev_rej   = 1'b0;
                        n_ev_price = o_hp;
                        n_ev_qty   = acc_sum;
                        n_acc      = '0;
                        n_ret      = S_STEP;
                        n_state    = S_FORM;
                    end else begin
                        n_acc = acc_sum;
                    end
                end else if (r_acc != '0) begin
                    n_ev_fill  = 1'b1;
                    n_ev_rej   = 1'b0;
                    n_ev_price = r_lvl_price;
                    n_ev_qty   = r_acc;
                    n_acc      = '0;
                    n_ret      = S_STEP;
                    n_state    = S_FORM;
                end else if (r_market) begin
                    if (!r_any) begin
                        n_ev_fill = 1'b0;
                        n_ev_rej  = 1'b0;
                        n_ret     = S_FIN;
                        n_state   = S_FORM;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (r_rem != '0) begin
                    n_state = S_REST;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_REST: begin
                cmd_to_buy = r_buy;
                cmd_key    = r_price;
                cmd_amt    = r_rem;
                n_ev_fill  = 1'b0;
                if (own_full) begin
                    n_ev_rej = 1'b1;
                    n_ret    = S_FIN;
                    n_state  = S_FORM;
                end else begin
                    cmd_op   = OP_INS;
                    n_ev_rej = 1'b0;
                    if (r_buy) begin
                        n_tot_bid = r_tot_bid + LW'(r_rem);
                    end else begin
                        n_tot_ask = r_tot_ask + LW'(r_rem);
                    end
                    if (show) begin
                        n_ret   = S_FIN;
                        n_state = S_FORM;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FORM: begin
                if (!r_pv || out_free) begin
                    n_state = r_ret;
                end
            end
            S_FIN: begin
                if (!r_pv || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ctl_buy  = '{op: (cmd_to_buy ? cmd_op : OP_NOP), buy: 1'b1};
    assign ctl_sell = '{op: (cmd_to_buy ? OP_NOP : cmd_op), buy: 1'b0};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_tot_bid <= '0;
            r_tot_ask <= '0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_tot_bid <= n_tot_bid;
            r_tot_ask <= n_tot_ask;
            if (r_state == S_IDLE && accept) begin
                r_any <= 1'b0;
            end else if (r_state == S_FORM && (!r_pv || out_free)) begin
                r_any <= 1'b1;
            end
            if (r_state == S_FORM && (!r_pv || out_free)) begin
                r_pv <= 1'b1;
            end else if (r_state == S_FIN && out_free) begin
                r_pv <= 1'b0;
            end
            if (r_pv && out_free && (r_state == S_FORM || r_state == S_FIN)) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // order, holding and output payload
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_acc       <= n_acc;
        r_lvl_price <= n_lvl_price;
        r_ev_fill   <= n_ev_fill;
        r_ev_rej    <= n_ev_rej;
        r_ev_price  <= n_ev_price;
        r_ev_qty    <= n_ev_qty;
        if (r_state == S_IDLE && accept) begin
            r_market  <= i_action;
            r_buy     <= i_side;
            r_price   <= i_price;
            r_clipped <= clip;
        end
        if (r_pv && out_free && (r_state == S_FORM || r_state == S_FIN)) begin
            r_o_ap   <= r_p_ap;
            r_o_aq   <= r_p_aq;
            r_o_apr  <= r_p_apr;
            r_o_bp   <= r_p_bp;
            r_o_bq   <= r_p_bq;
            r_o_bpr  <= r_p_bpr;
            r_o_fill <= r_p_fill;
            r_o_fp   <= r_p_fp;
            r_o_fq   <= r_p_fq;
            r_o_clip <= r_p_clip;
            r_o_rej  <= r_p_rej;
            r_o_last <= (r_state == S_FIN);
        end
        if (r_state == S_FORM && (!r_pv || out_free)) begin
            r_p_apr  <= s_hv;
            r_p_ap   <= s_hv ? s_hp : '0;
            r_p_aq   <= s_hv ? s_hl : '0;
            r_p_bpr  <= b_hv;
            r_p_bp   <= b_hv ? b_hp : '0;
            r_p_bq   <= b_hv ? b_hl : '0;
            r_p_fill <= r_ev_fill;
            r_p_fp   <= r_ev_fill ? r_ev_price : '0;
            r_p_fq   <= r_ev_fill ? r_ev_qty : '0;
            r_p_clip <= r_clipped;
            r_p_rej  <= r_ev_rej;
        end
    end

    // buy book
    lobm_book #(.N(ORDERS_PER_SIDE), .PB(PB), .QB(QB), .LW(LW)) u_buy (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_buy),
        .i_key        (cmd_key),
        .i_amt        (cmd_amt),
        .o_head_valid (b_hv),
        .o_head_price (b_hp),
        .o_head_qty   (b_hq),
        .o_head_level (b_hl),
        .o_next_valid (b_nv),
        .o_next_price (b_np),
        .o_full       (b_full)
    );

    // sell book
    lobm_book #(.N(ORDERS_PER_SIDE), .PB(PB), .QB(QB), .LW(LW)) u_sell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_sell),
        .i_key        (cmd_key),
        .i_amt        (cmd_amt),
        .o_head_valid (s_hv),
        .o_head_price (s_hp),
        .o_head_qty   (s_hq),
        .o_head_level (s_hl),
        .o_next_valid (s_nv),
        .o_next_price (s_np),
        .o_full       (s_full)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_best_ask    = r_o_ap;
    assign o_ask_depth   = r_o_aq;
    assign o_ask_present = r_o_apr;
    assign o_best_bid    = r_o_bp;
    assign o_bid_depth   = r_o_bq;
    assign o_bid_present = r_o_bpr;
    assign o_has_fill    = r_o_fill;
    assign o_trade_price = r_o_fp;
    assign o_trade_qty   = r_o_fq;
    assign o_clipped     = r_o_clip;
    assign o_rejected    = r_o_rej;
    assign o_last        = r_o_last;

endmodule

@@ src/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "limit_order_book_matcher_top_defines.svh"

module lobm_checker #(
    parameter int PRICE_BITS = 32,
    parameter int QW         = 32,
    parameter int LW         = 37
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PRICE_BITS-1:0] o_best_ask,
    input logic [LW-1:0]         o_ask_depth,
    input logic                  o_ask_present,
    input logic                  o_has_fill,
    input logic [PRICE_BITS-1:0] o_trade_price,
    input logic [QW-1:0]         o_trade_qty,
    input logic                  o_rejected
);

    // no word straight after reset
    `LOBM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

    // a stalled word holds
    `LOBM_ASSERT(a_stall_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_trade_price) && $stable(o_trade_qty))

    // fill fields are zero without a fill
    `LOBM_ASSERT(a_no_fill_zero, o_out_valid && !o_has_fill |-> o_trade_price == '0 && o_trade_qty == '0)

    // empty sell book shows zero top
    `LOBM_ASSERT(a_empty_ask, o_out_valid && !o_ask_present |-> o_best_ask == '0 && o_ask_depth == '0)

    // a reject never reports a fill
    `LOBM_ASSERT(a_rej_no_fill, o_out_valid |-> !(o_has_fill && o_rejected))

endmodule

bind limit_order_book_matcher_top lobm_checker #(
    .PRICE_BITS (PRICE_BITS),
    .QW         (QUANTITY_BITS),
    .LW         (QUANTITY_BITS + $clog2(ORDERS_PER_SIDE))
) u_lobm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_best_ask    (o_best_ask),
    .o_ask_depth   (o_ask_depth),
    .o_ask_present (o_ask_present),
    .o_has_fill    (o_has_fill),
    .o_trade_price (o_trade_price),
    .o_trade_qty   (o_trade_qty),
    .o_rejected    (o_rejected)
);
